FILE: rtl/fwdf_pkg.sv
`default_nettype none
package fwdf_pkg;

    localparam int MAX_CHARS_DEF = 15;
    localparam int VALUE_W       = 32;
    localparam int WIDTH_W       = 4;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int NUM_DIGITS    = 10;
    localparam int BIT_CNT_W     = $clog2(VALUE_W);
    localparam int S_TDATA_W     = ((VALUE_W + WIDTH_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    localparam logic OP_SPACE_PAD = 1'b0;
    localparam logic OP_ZERO_PAD  = 1'b1;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic bit_in;
    } chain_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/fwdf_cell.sv
`default_nettype none
module fwdf_cell
(
    input  wire logic            clk,
    input  wire logic            clear,
    input  wire logic            shift,
    input  wire logic            bit_in,
    input  wire logic            nz_in,
    output fwdf_pkg::digit_t     digit,
    output logic                 bit_out,
    output logic                 nz_out
);

    fwdf_pkg::digit_t digit_reg;
    fwdf_pkg::digit_t digit_next;
    fwdf_pkg::digit_t adj;

    // add-3 correction before each doubling
    always_comb
    begin
        adj = (digit_reg >= fwdf_pkg::DIGIT_W'(5)) ? digit_reg + fwdf_pkg::DIGIT_W'(3)
                                                   : digit_reg;
        digit_next = digit_reg;
        if (clear)
        begin
            digit_next = '0;
        end
        else if (shift)
        begin
            digit_next = {adj[fwdf_pkg::DIGIT_W-2:0], bit_in};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit   = digit_reg;
    assign bit_out = adj[fwdf_pkg::DIGIT_W-1];
    assign nz_out  = nz_in | (digit_reg != '0);

endmodule
`default_nettype wire

FILE: rtl/fwdf_chain.sv
`default_nettype none
module fwdf_chain
(
    input  wire logic                                           clk,
    input  wire fwdf_pkg::chain_ctrl_t                          ctrl,
    output fwdf_pkg::digit_t [fwdf_pkg::NUM_DIGITS-1:0]         digits,
    output logic             [fwdf_pkg::NUM_DIGITS-1:0]         nz_at_or_above
);

    logic [fwdf_pkg::NUM_DIGITS:0] carry;
    logic [fwdf_pkg::NUM_DIGITS:0] nz;

    assign carry[0]                  = ctrl.bit_in;
    assign nz[fwdf_pkg::NUM_DIGITS]  = 1'b0;

    for (genvar i = 0; i < fwdf_pkg::NUM_DIGITS; i++)
    begin : g_cell
        fwdf_cell u_cell
        (
            .clk     (clk),
            .clear   (ctrl.clear),
            .shift   (ctrl.shift),
            .bit_in  (carry[i]),
            .nz_in   (nz[i+1]),
            .digit   (digits[i]),
            .bit_out (carry[i+1]),
            .nz_out  (nz[i])
        );
    end

    assign nz_at_or_above = nz[fwdf_pkg::NUM_DIGITS-1:0];

endmodule
`default_nettype wire

FILE: rtl/fixed_width_decimal_formatter_top.sv
`default_nettype none
// channel  | tdata                                  | tuser    | tlast
// s_axis   | value[31:0], width[35:32]              | opcode (1 = zero pad) | -
// m_axis   | char_out[7:0]                          | -        | last
//
// Each accepted value is converted through the BCD cell row
// (one magnitude bit per cycle) and then emitted one character at a time.
// s_tready is high only while idle; the final character may still wait in the
// output register when the next word is taken.
// Reset clears control state; digit cells are cleared on each accepted word.
// A stalled output holds its word and pauses character generation.
module fixed_width_decimal_formatter_top
#(
    parameter int MAX_CHARS = fwdf_pkg::MAX_CHARS_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fwdf_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], width[35:32]
    input  wire logic                             s_tuser,  // opcode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [fwdf_pkg::CHAR_W-1:0]           m_tdata,  // char_out[7:0]
    output logic                                  m_tlast
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam int EXT_W = (CNT_W > fwdf_pkg::WIDTH_W) ? CNT_W : fwdf_pkg::WIDTH_W;
    localparam int POS_W = $clog2(MAX_CHARS);

    typedef enum logic [1:0] {IDLE, CONV, EMIT} state_t;

    state_t                              state_reg, state_next;
    logic [fwdf_pkg::VALUE_W-1:0]        mag_reg, mag_next;
    logic [fwdf_pkg::BIT_CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic [POS_W-1:0]                    top_reg, top_next;
    logic                                neg_reg, neg_next;
    logic                                zero_reg, zero_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [fwdf_pkg::CHAR_W-1:0]         m_tdata_reg, m_tdata_next;
    logic                                m_tlast_reg, m_tlast_next;

    fwdf_pkg::chain_ctrl_t                               ctrl;
    fwdf_pkg::digit_t [fwdf_pkg::NUM_DIGITS-1:0]         digits;
    logic             [fwdf_pkg::NUM_DIGITS-1:0]         nz_at_or_above;

    logic [fwdf_pkg::VALUE_W-1:0]   in_value;
    logic [fwdf_pkg::WIDTH_W-1:0]   in_width;
    logic                           in_neg;
    logic                           in_zero;
    logic [EXT_W-1:0]               w_ext;
    logic [EXT_W-1:0]               w_max;
    logic [EXT_W-1:0]               w_clamp;
    logic [EXT_W-1:0]               start_pos;
    logic                           s_fire;
    logic                           load_out;
    fwdf_pkg::digit_t               sel_digit;
    logic                           sel_nz;
    logic [fwdf_pkg::CHAR_W-1:0]    ch;

    assign in_value = s_tdata[fwdf_pkg::VALUE_W-1:0];
    assign in_width = s_tdata[fwdf_pkg::VALUE_W +: fwdf_pkg::WIDTH_W];
    assign in_neg   = in_value[fwdf_pkg::VALUE_W-1];
    assign in_zero  = (s_tuser == fwdf_pkg::OP_ZERO_PAD);
    assign s_tready = (state_reg == IDLE);
    assign s_fire   = s_tvalid & s_tready;

    always_comb
    begin
        w_ext   = EXT_W'(in_width);
        w_max   = in_zero ? EXT_W'(MAX_CHARS) : EXT_W'(MAX_CHARS - 1);
        w_clamp = w_ext;
        if (w_ext == '0)
        begin
            w_clamp = EXT_W'(1);
        end
        else if (w_ext > w_max)
        begin
            w_clamp = w_max;
        end
        start_pos = (in_neg || in_zero) ? w_clamp - EXT_W'(1) : w_clamp;
    end

    assign ctrl.clear  = s_fire;
    assign ctrl.shift  = (state_reg == CONV);
    assign ctrl.bit_in = mag_reg[fwdf_pkg::VALUE_W-1];

    fwdf_chain u_chain
    (
        .clk            (clk),
        .ctrl           (ctrl),
        .digits         (digits),
        .nz_at_or_above (nz_at_or_above)
    );

    // positions above the cell row read as zero
    always_comb
    begin
        sel_digit = '0;
        sel_nz    = 1'b0;
        for (int i = 0; i < fwdf_pkg::NUM_DIGITS; i++)
        begin
            if (32'(pos_reg) == i)
            begin
                sel_digit = digits[i];
                sel_nz    = nz_at_or_above[i];
            end
        end
        if (neg_reg && (pos_reg == top_reg))
        begin
            ch = fwdf_pkg::CH_MINUS;
        end
        else if (!zero_reg && !neg_reg && (pos_reg != '0) && !sel_nz)
        begin
            ch = fwdf_pkg::CH_SPACE;
        end
        else
        begin
            ch = fwdf_pkg::CH_ZERO | fwdf_pkg::CHAR_W'(sel_digit);
        end
    end

    assign load_out = (state_reg == EMIT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        bit_cnt_next  = bit_cnt_reg;
        pos_next      = pos_reg;
        top_next      = top_reg;
        neg_next      = neg_reg;
        zero_next     = zero_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (s_fire)
                begin
                    mag_next     = in_neg ? (fwdf_pkg::VALUE_W'(0) - in_value) : in_value;
                    bit_cnt_next = fwdf_pkg::BIT_CNT_W'(fwdf_pkg::VALUE_W - 1);
                    pos_next     = POS_W'(start_pos);
                    top_next     = POS_W'(start_pos);
                    neg_next     = in_neg;
                    zero_next    = in_zero;
                    state_next   = CONV;
                end
            end
            CONV:
            begin
                mag_next     = {mag_reg[fwdf_pkg::VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - fwdf_pkg::BIT_CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    state_next = EMIT;
                end
            end
            EMIT:
            begin
                if (load_out)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ch;
                    m_tlast_next  = (pos_reg == '0);
                    if (pos_reg == '0)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - POS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bit_cnt_reg <= bit_cnt_next;
        pos_reg     <= pos_next;
        top_reg     <= top_next;
        neg_reg     <= neg_next;
        zero_reg    <= zero_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

FILE: rtl/fwdf_checker.sv
`default_nettype none
module fwdf_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [fwdf_pkg::CHAR_W-1:0]      m_tdata,
    input wire logic                             m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    // one value at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while converting");

    // while idle only the final character of a value can be pending
    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tlast)
        else $error("idle with a non-final character pending");

    // only digits, space or minus leave the block
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == fwdf_pkg::CH_SPACE) || (m_tdata == fwdf_pkg::CH_MINUS)
                     || ((m_tdata >= fwdf_pkg::CH_ZERO)
                         && (m_tdata <= fwdf_pkg::CH_ZERO + fwdf_pkg::CHAR_W'(9))))
        else $error("output character out of range");

endmodule

bind fixed_width_decimal_formatter_top fwdf_checker u_fwdf_checker (.*);
`default_nettype wire
